FILE: hw/rtl/afce_pkg.sv
// Shared types and constants for the ADC frame channel extremes block.
// Depends on nothing; imported by every module of the block.

package afce_pkg;

	// Frame format.
	localparam logic [31:0] SYNC_WORD = 32'hFFFF_FFFF;

	// Register reset values.
	localparam logic [7:0]  CHANNEL_CODE_RST    = 8'hEA;
	localparam logic [11:0] MAX_FRAME_BYTES_RST = 12'd1500;

	// Register indexes on the configuration port.
	localparam logic REG_CHANNEL_CODE    = 1'b0;
	localparam logic REG_MAX_FRAME_BYTES = 1'b1;

	// Volts in Q.20 is round(mag * 2^14 / 9375). The quotient is formed in two
	// parts, each an exact multiply by a rounded-up reciprocal of 9375.
	localparam logic [13:0] VOLT_DIV      = 14'd9375;
	localparam logic [24:0] RECIP_HI      = 25'd29320311;   // ceil(2^38 / 9375)
	localparam int          RECIP_HI_SH   = 38;
	localparam logic [28:0] RECIP_LO      = 29'd469124962;  // ceil(2^42 / 9375)
	localparam int          RECIP_LO_SH   = 42;
	localparam logic [27:0] ROUND_BIAS    = 28'd4687;       // (9375 - 1) / 2

	// Sample code together with the running extremes that include it.
	typedef struct packed {
		logic signed [23:0] code;
		logic [22:0]        first_max;
		logic [22:0]        second_max;
		logic signed [23:0] first_min;
		logic signed [23:0] second_min;
	} stat_t;

endpackage

FILE: hw/rtl/afce_parser.sv
// Input register, frame parser and running extremes tracker.
// Depends on afce_pkg; feeds the volts pipeline with one request per emitted sample.

module afce_parser
	import afce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  channel_code,
	input  logic [11:0] max_frame_bytes,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [31:0] word,
	input  logic        clear,
	output logic        valid_s2,
	input  logic        ready_s2,
	output stat_t       stat_s2,
	output logic [23:0] mag_s2
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_LENGTH,
		PH_PAYLOAD
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [9:0]         left_q, left_d, left_dec;
	logic [22:0]        top_max_q, top_max_d, next_max_q, next_max_d;
	logic signed [23:0] top_min_q, top_min_d, next_min_q, next_min_d;

	logic               valid_s1;
	logic [31:0]        word_s1;
	logic               clear_s1;

	logic               s2_free;
	logic               emit;
	logic signed [23:0] code_w;
	logic [22:0]        code_pos;
	logic               too_long;

	assign s2_free    = !valid_s2 || ready_s2;
	assign item_ready = !valid_s1 || s2_free;

	assign code_w   = signed'(word_s1[23:0]);
	assign code_pos = word_s1[22:0];
	assign too_long = (word_s1[31:12] != 20'd0) || (word_s1[11:0] > max_frame_bytes);
	assign left_dec = (left_q != 10'd0) ? left_q - 10'd1 : left_q;

	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		top_max_d  = top_max_q;
		next_max_d = next_max_q;
		top_min_d  = top_min_q;
		next_min_d = next_min_q;
		emit       = 1'b0;
		if (clear_s1) begin
			phase_d    = PH_HUNT;
			left_d     = 10'd0;
			top_max_d  = 23'd0;
			next_max_d = 23'd0;
			top_min_d  = 24'sd0;
			next_min_d = 24'sd0;
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (word_s1 == SYNC_WORD)
						phase_d = PH_HEADER;
				end
				PH_HEADER: begin
					phase_d = word_s1[31] ? PH_HUNT : PH_LENGTH;
				end
				PH_LENGTH: begin
					if (too_long || word_s1[31:2] == 30'd0) begin
						phase_d = PH_HUNT;
						left_d  = 10'd0;
					end else begin
						phase_d = PH_PAYLOAD;
						left_d  = word_s1[11:2];
					end
				end
				PH_PAYLOAD: begin
					left_d = left_dec;
					if (left_dec == 10'd0)
						phase_d = PH_HUNT;
					if (word_s1[31:24] == channel_code) begin
						emit = 1'b1;
						// Only distinct values displace the runner-up.
						if (!code_w[23] && code_pos != 23'd0) begin
							if (code_pos > top_max_q) begin
								next_max_d = top_max_q;
								top_max_d  = code_pos;
							end else if (code_pos < top_max_q && code_pos > next_max_q) begin
								next_max_d = code_pos;
							end
						end else if (code_w[23]) begin
							if (code_w < top_min_q) begin
								next_min_d = top_min_q;
								top_min_d  = code_w;
							end else if (code_w > top_min_q && code_w < next_min_q) begin
								next_min_d = code_w;
							end
						end
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			phase_q    <= PH_HUNT;
			left_q     <= 10'd0;
			top_max_q  <= 23'd0;
			next_max_q <= 23'd0;
			top_min_q  <= 24'sd0;
			next_min_q <= 24'sd0;
		end else begin
			if (item_ready)
				valid_s1 <= item_valid;
			if (s2_free)
				valid_s2 <= valid_s1 && emit;
			if (valid_s1 && s2_free) begin
				phase_q    <= phase_d;
				left_q     <= left_d;
				top_max_q  <= top_max_d;
				next_max_q <= next_max_d;
				top_min_q  <= top_min_d;
				next_min_q <= next_min_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			word_s1  <= word;
			clear_s1 <= clear;
		end
		if (s2_free) begin
			stat_s2.code       <= code_w;
			stat_s2.first_max  <= top_max_d;
			stat_s2.second_max <= next_max_d;
			stat_s2.first_min  <= top_min_d;
			stat_s2.second_min <= next_min_d;
			mag_s2             <= code_w[23] ? 24'(-code_w) : word_s1[23:0];
		end
	end

endmodule

FILE: hw/rtl/afce_volts.sv
// Pipeline that scales the sample magnitude to volts, carrying the statistics alongside.
// Depends on afce_pkg; sits between the parser and the result register.

module afce_volts
	import afce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s2,
	output logic        ready_s2,
	input  stat_t       stat_s2,
	input  logic [23:0] mag_s2,
	output logic        valid_s5,
	input  logic        ready_s5,
	output stat_t       stat_s5,
	output logic [23:0] mag_q_s5
);

	logic        valid_s3, valid_s4;
	logic        ready_s3, ready_s4;
	stat_t       stat_s3, stat_s4;
	logic [23:0] mag_s3;
	logic [9:0]  hi_s3, hi_s4;
	logic [13:0] rem_s4;

	logic [48:0] prod_hi;
	logic [23:0] rem_full;
	logic [27:0] num_lo;
	logic [56:0] prod_lo;

	// Whole multiples of 9375 in the magnitude.
	assign prod_hi  = {25'd0, mag_s2} * {24'd0, RECIP_HI};
	assign rem_full = mag_s3 - {14'd0, hi_s3} * {10'd0, VOLT_DIV};
	// The remainder part yields below 2^14, so it fills the low bits of the quotient.
	assign num_lo   = {rem_s4, 14'd0} + ROUND_BIAS;
	assign prod_lo  = {29'd0, num_lo} * {28'd0, RECIP_LO};

	assign ready_s4 = !valid_s5 || ready_s5;
	assign ready_s3 = !valid_s4 || ready_s4;
	assign ready_s2 = !valid_s3 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s2)
				valid_s3 <= valid_s2;
			if (ready_s3)
				valid_s4 <= valid_s3;
			if (ready_s4)
				valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			stat_s3 <= stat_s2;
			mag_s3  <= mag_s2;
			hi_s3   <= prod_hi[RECIP_HI_SH+9:RECIP_HI_SH];
		end
		if (ready_s3) begin
			stat_s4 <= stat_s3;
			hi_s4   <= hi_s3;
			rem_s4  <= rem_full[13:0];
		end
		if (ready_s4) begin
			stat_s5  <= stat_s4;
			mag_q_s5 <= {hi_s4, prod_lo[RECIP_LO_SH+13:RECIP_LO_SH]};
		end
	end

endmodule

FILE: hw/rtl/adc_frame_channel_extremes.sv
// Top level of the ADC frame channel extremes block: register port, parser,
// volts pipeline and result register. Depends on afce_pkg, afce_parser and afce_volts.
//
// Capture words enter on the item channel (item_valid/item_ready, fields word
// and clear). A request with clear set sends the parser back to hunting for the
// sync word and zeroes all extremes; it yields no result. Payload words of the
// selected channel each yield one result on the result channel
// (result_valid/result_ready): the sign-extended code, its value in volts as
// Q.20, and the first and second distinct maxima and minima including it.
// One word is taken every cycle while results can move on; the only loop is
// the parser and extremes update. When the receiver stalls, results collect
// in the pipeline stages and the result register. Once the stage behind the
// parser holds a result that cannot move on, the word in the input register
// waits and item_ready falls, whether or not that word yields a result.
// Reset puts the parser in the hunt state, zeroes the extremes, empties the
// pipeline and loads channel_code with 0xEA and max_frame_bytes with 1500.
// Registers: channel_code at byte address 0, max_frame_bytes at address 4;
// users must see they are written only while the block is idle (not enforced).

module adc_frame_channel_extremes
	import afce_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [31:0]        word,
	input  logic               clear,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [23:0] sample_code,
	output logic signed [24:0] sample_volts_q20,
	output logic [22:0]        first_max,
	output logic [22:0]        second_max,
	output logic signed [23:0] first_min,
	output logic signed [23:0] second_min
);

	logic [7:0]  channel_code_q;
	logic [11:0] max_frame_bytes_q;

	logic        valid_s2, ready_s2;
	stat_t       stat_s2;
	logic [23:0] mag_s2;
	logic        valid_s5, ready_s5;
	stat_t       stat_s5;
	logic [23:0] mag_q_s5;

	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			REG_CHANNEL_CODE:    prdata = {24'd0, channel_code_q};
			REG_MAX_FRAME_BYTES: prdata = {20'd0, max_frame_bytes_q};
			default:             prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_code_q    <= CHANNEL_CODE_RST;
			max_frame_bytes_q <= MAX_FRAME_BYTES_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_CHANNEL_CODE:    channel_code_q    <= pwdata[7:0];
				REG_MAX_FRAME_BYTES: max_frame_bytes_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	afce_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.channel_code    (channel_code_q),
		.max_frame_bytes (max_frame_bytes_q),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.word            (word),
		.clear           (clear),
		.valid_s2        (valid_s2),
		.ready_s2        (ready_s2),
		.stat_s2         (stat_s2),
		.mag_s2          (mag_s2)
	);

	afce_volts u_volts (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.ready_s2 (ready_s2),
		.stat_s2  (stat_s2),
		.mag_s2   (mag_s2),
		.valid_s5 (valid_s5),
		.ready_s5 (ready_s5),
		.stat_s5  (stat_s5),
		.mag_q_s5 (mag_q_s5)
	);

	assign ready_s5 = !result_valid || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (ready_s5)
			result_valid <= valid_s5;
	end

	always_ff @(posedge clk) begin
		if (ready_s5) begin
			sample_code      <= stat_s5.code;
			sample_volts_q20 <= stat_s5.code[23] ? 25'(-{1'b0, mag_q_s5})
			                                     : {1'b0, mag_q_s5};
			first_max        <= stat_s5.first_max;
			second_max       <= stat_s5.second_max;
			first_min        <= stat_s5.first_min;
			second_min       <= stat_s5.second_min;
		end
	end

endmodule

FILE: tb/sv/adc_frame_channel_extremes_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for adc_frame_channel_extremes: it drives capture words and register
// writes, predicts every sample and extremes result, and checks results in order.
// Depends on afce_pkg and the adc_frame_channel_extremes RTL.

module adc_frame_channel_extremes_test
	import afce_pkg::*;
;

	typedef enum logic [1:0] {
		SEEK_SYNC,
		EXPECT_HEADER,
		EXPECT_LENGTH,
		IN_PAYLOAD
	} frame_phase_t;

	typedef struct packed {
		logic signed [23:0] code;
		logic signed [24:0] volts;
		logic [22:0]        fmax;
		logic [22:0]        smax;
		logic signed [23:0] fmin;
		logic signed [23:0] smin;
	} sample_rec_t;

	class extremes_scoreboard;
		logic [7:0]   chan_code;
		logic [11:0]  frame_limit;
		frame_phase_t phase;
		logic [9:0]   words_left;
		int           top_max, next_max, top_min, next_min;
		sample_rec_t  awaited[$];
		int           n_requests, n_clears, n_results, n_errors;

		function new();
			chan_code = CHANNEL_CODE_RST;
			frame_limit = MAX_FRAME_BYTES_RST;
			clear_stats();
		endfunction

		function void clear_stats();
			phase = SEEK_SYNC;
			words_left = '0;
			top_max = 0;
			next_max = 0;
			top_min = 0;
			next_min = 0;
		endfunction

		function void write_reg(logic idx, logic [31:0] value);
			if (idx == REG_CHANNEL_CODE) chan_code = value[7:0];
			else frame_limit = value[11:0];
		endfunction

		function logic [31:0] reg_value(logic idx);
			return (idx == REG_CHANNEL_CODE) ? {24'd0, chan_code} : {20'd0, frame_limit};
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Volts are code * 10 / 6e6, held as Q.20 and rounded half away from zero.
		function longint q20_of(int code);
			longint mag, quo, rem;
			mag = (code < 0) ? -longint'(code) : longint'(code);
			quo = (mag << 20) / 600000;
			rem = (mag << 20) % 600000;
			if (2 * rem >= 600000) quo++;
			return (code < 0) ? -quo : quo;
		endfunction

		function void note_request(logic [31:0] w, logic c);
			int          code;
			longint      volts;
			sample_rec_t rec;
			n_requests++;
			if (c) begin
				n_clears++;
				clear_stats();
				return;
			end
			case (phase)
				SEEK_SYNC: begin
					if (w == SYNC_WORD) phase = EXPECT_HEADER;
					return;
				end
				EXPECT_HEADER: begin
					phase = w[31] ? SEEK_SYNC : EXPECT_LENGTH;
					return;
				end
				EXPECT_LENGTH: begin
					if (w > frame_limit || w[31:2] == 0) begin
						phase = SEEK_SYNC;
						words_left = '0;
					end else begin
						words_left = w[11:2];
						phase = IN_PAYLOAD;
					end
					return;
				end
				default: ;
			endcase
			if (words_left != 0) words_left--;
			if (words_left == 0) phase = SEEK_SYNC;
			if (w[31:24] != chan_code) return;

			code = int'($signed(w[23:0]));
			// Zero is the baseline on both sides, so a zero code moves no extreme.
			if (code > 0) begin
				if (code > top_max) begin
					next_max = top_max;
					top_max = code;
				end else if (code < top_max && code > next_max) begin
					next_max = code;
				end
			end else if (code < 0) begin
				if (code < top_min) begin
					next_min = top_min;
					top_min = code;
				end else if (code > top_min && code < next_min) begin
					next_min = code;
				end
			end
			volts = q20_of(code);
			rec.code = code[23:0];
			rec.volts = volts[24:0];
			rec.fmax = top_max[22:0];
			rec.smax = next_max[22:0];
			rec.fmin = top_min[23:0];
			rec.smin = next_min[23:0];
			awaited.push_back(rec);
		endfunction

		function void match(string name, logic signed [24:0] want, logic signed [24:0] got);
			if (got !== want) begin
				n_errors++;
				$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(sample_rec_t got);
			sample_rec_t want;
			n_results++;
			if (awaited.size() == 0) begin
				n_errors++;
				$display("%0t ns: result with no request awaiting it, expected none, got code %0d",
					$time, got.code);
				return;
			end
			want = awaited.pop_front();
			match("sample_code", want.code, got.code);
			match("sample_volts_q20", want.volts, got.volts);
			match("first_max", want.fmax, got.fmax);
			match("second_max", want.smax, got.smax);
			match("first_min", want.fmin, got.fmin);
			match("second_min", want.smin, got.smin);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               pready;
	logic               item_valid, item_ready;
	logic [31:0]        word;
	logic               clear;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic signed [23:0] sample_code;
	logic signed [24:0] sample_volts_q20;
	logic [22:0]        first_max, second_max;
	logic signed [23:0] first_min, second_min;

	adc_frame_channel_extremes dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.word(word),
		.clear(clear),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sample_code(sample_code),
		.sample_volts_q20(sample_volts_q20),
		.first_max(first_max),
		.second_max(second_max),
		.first_min(first_min),
		.second_min(second_min)
	);

	extremes_scoreboard sb = new();
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          settings_written = 0;

	logic [23:0] corner_codes [5] = '{24'h7F_FFFF, 24'h80_0000, 24'h00_0000, 24'h00_0001,
		24'hFF_FFFF};

	// Each entry is {clear, word}.
	logic [32:0] directed_reqs [24] = '{
		{1'b0, 32'hFFFF_FFFF}, {1'b0, 32'h7FFF_FFFF}, {1'b0, 32'h0000_0016},
		{1'b0, 32'hEA7F_FFFF}, {1'b0, 32'hEA80_0000}, {1'b0, 32'hEA00_0000},
		{1'b0, 32'hFFFF_FFFF}, {1'b0, 32'hEA7F_FFFF},
		{1'b0, 32'hFFFF_FFFF}, {1'b0, 32'h8000_0000},
		{1'b0, 32'hFFFF_FFFF}, {1'b0, 32'hFFFF_FFFF},
		{1'b0, 32'hFFFF_FFFF}, {1'b0, 32'h0000_0000}, {1'b0, 32'h0000_0003},
		{1'b0, 32'hFFFF_FFFF}, {1'b0, 32'h0000_0000}, {1'b0, 32'h0000_05DD},
		{1'b0, 32'hFFFF_FFFF}, {1'b0, 32'h0000_0000}, {1'b0, 32'h0000_0008},
		{1'b0, 32'hEAFF_FFFF}, {1'b1, 32'hFFFF_FFFF}, {1'b0, 32'hEA00_0001}
	};

	function automatic bit chance(int unsigned pct);
		return $urandom_range(99) < pct;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) result_ready <= !chance(recv_stall_pct);

	always @(posedge clk) begin : result_monitor
		sample_rec_t got;
		if (arst_n && result_valid && result_ready) begin
			got.code = sample_code;
			got.volts = sample_volts_q20;
			got.fmax = first_max;
			got.smax = second_max;
			got.fmin = first_min;
			got.smin = second_min;
			sb.check_result(got);
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken,
	// with valid still high so that the next request can follow without a gap.
	task automatic send_item(input logic [31:0] w, input logic c);
		while (chance(send_idle_pct)) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		word <= w;
		clear <= c;
		do @(posedge clk); while (!item_ready);
		sb.note_request(w, c);
		@(negedge clk);
	endtask

	// Words that yield no result may still be in the parser after the last result, hence the extra cycles.
	task automatic drain_pipeline();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic program_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk) penable <= 1'b1;
		@(posedge clk) sb.write_reg(idx, value);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk) penable <= 1'b1;
		@(posedge clk);
		if (prdata !== sb.reg_value(idx)) begin
			sb.n_errors++;
			$display("%0t ns: register %0d read back expected %0d, got %0d", $time, idx,
				sb.reg_value(idx), prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		settings_written++;
		@(negedge clk);
	endtask

	task automatic send_traffic();
		int unsigned kind, limit, nbytes, pick;
		logic [7:0]  top;
		logic [23:0] low;
		kind = $urandom_range(99);
		limit = 32'(sb.frame_limit);
		if (kind < 4) begin
			send_item($urandom, 1'b1);
		end else if (kind < 12) begin
			send_item($urandom, 1'b0);
		end else if (kind < 18) begin
			send_item(SYNC_WORD, 1'b0);
			send_item({1'b1, 31'($urandom)}, 1'b0);
		end else if (kind < 26) begin
			// Frames whose length word is refused.
			send_item(SYNC_WORD, 1'b0);
			send_item({1'b0, 31'($urandom)}, 1'b0);
			if (chance(50)) send_item($urandom_range(3), 1'b0);
			else if (limit == 4095 || chance(50)) send_item($urandom | 32'h1000, 1'b0);
			else send_item($urandom_range(4095, limit + 1), 1'b0);
		end else begin
			send_item(SYNC_WORD, 1'b0);
			send_item({1'b0, 31'($urandom)}, 1'b0);
			if (limit < 4) nbytes = $urandom_range(limit, 0);
			else if (chance(3)) nbytes = limit;
			else nbytes = $urandom_range((limit < 64) ? limit : 64, 4);
			send_item(nbytes, 1'b0);
			for (int i = 0; i < nbytes / 4; i++) begin
				if ($urandom_range(199) == 0) begin
					send_item($urandom, 1'b1);
					break;
				end
				pick = $urandom_range(99);
				if (pick < 75) top = sb.chan_code;
				else if (pick < 85) top = 8'hFF;
				else top = 8'($urandom);
				pick = $urandom_range(99);
				if (pick < 15) low = corner_codes[$urandom_range(4)];
				else if (pick < 30) low = 24'($urandom_range(64)) - 24'd32;
				else low = 24'($urandom);
				send_item({top, low}, 1'b0);
			end
		end
	endtask

	initial begin
		int unsigned target;
		logic [7:0]  chan;
		logic [11:0] limit;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		word = '0;
		clear = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_reqs[i]) send_item(directed_reqs[i][31:0], directed_reqs[i][32]);

		for (int ph = 0; ph < 8; ph++) begin
			drain_pipeline();
			case (ph)
				0: begin chan = 8'hEA; limit = 12'd1500; end
				1: begin chan = 8'h00; limit = 12'd4095; end
				3: begin chan = 8'hFF; limit = 12'd0; end
				5: begin chan = 8'hFF; limit = 12'd64; end
				7: begin chan = 8'h00; limit = 12'd4; end
				default: begin
					chan = 8'($urandom_range(255));
					limit = 12'($urandom_range(700, 4));
				end
			endcase
			program_reg(REG_CHANNEL_CODE, {24'd0, chan});
			program_reg(REG_MAX_FRAME_BYTES, {20'd0, limit});
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 77; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 77; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			target = sb.n_requests + 200;
			while (sb.n_requests < target) send_traffic();
			// Sometimes leave a frame open so that the next settings land mid-frame.
			if (sb.frame_limit >= 16 && chance(50)) begin
				send_item(SYNC_WORD, 1'b0);
				send_item(32'h0000_0000, 1'b0);
				send_item(32'd16, 1'b0);
				send_item({sb.chan_code, 24'($urandom)}, 1'b0);
			end
		end

		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Run sent %0d requests (%0d clears) and checked %0d results over %0d register writes.",
			sb.n_requests, sb.n_clears, sb.n_results, settings_written);
		if (sb.n_errors == 0) begin
			$display("** adc_frame_channel_extremes: PASSED **");
		end else begin
			$display("** adc_frame_channel_extremes: FAILED **");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Run stopped: time limit reached with %0d results outstanding.", sb.pending());
		$display("** adc_frame_channel_extremes: FAILED **");
		$finish;
	end

endmodule

FILE: adc_frame_channel_extremes.f
hw/rtl/afce_pkg.sv
hw/rtl/afce_parser.sv
hw/rtl/afce_volts.sv
hw/rtl/adc_frame_channel_extremes.sv
tb/sv/adc_frame_channel_extremes_test.sv
